// ===== sv/urb_pkg.sv =====
// Shared types, register codes and constants of the ultrasonic ranger.
package urb_pkg;

    localparam int TRIG_W      = 8;
    localparam int LIMIT_W     = 16;
    localparam int BLINK_W     = 4;
    localparam int DIST_W      = 9;
    localparam int DUTY_W      = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_TRIG_LOW  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRIG_HIGH = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ECHO_WAIT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ECHO_MAX  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLINK     = 3'd4;

    localparam logic [TRIG_W-1:0]  RST_TRIG_LOW  = 8'd4;
    localparam logic [TRIG_W-1:0]  RST_TRIG_HIGH = 8'd20;
    localparam logic [LIMIT_W-1:0] RST_ECHO_WAIT = 16'd65535;
    localparam logic [LIMIT_W-1:0] RST_ECHO_MAX  = 16'd46400;
    localparam logic [BLINK_W-1:0] RST_BLINK     = 4'd8;

    // input actions
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_SLOW  = 2'd2;

    // distance = floor(ticks * 343 / 40000) = (ticks * DIST_RECIP) >> DIST_SHIFT,
    // exact for every tick count below DIST_SAT_TICKS
    localparam int                DIST_SHIFT     = 32;
    localparam int                DIST_RECIP_W   = 26;
    localparam logic [25:0]       DIST_RECIP     = 26'd36829345;
    localparam logic [LIMIT_W-1:0] DIST_SAT_TICKS = 16'd59709;
    localparam logic [DIST_W-1:0] DIST_MAX       = 9'd511;

    localparam logic [DIST_W-1:0] NEAR_CM = 9'd12;
    localparam logic [DIST_W-1:0] FAR_CM  = 9'd46;
    localparam logic [DUTY_W-1:0] DUTY_NEAR = 8'd255;
    localparam logic [DUTY_W-1:0] DUTY_FAR  = 8'd26;

    localparam logic [BLINK_W-1:0] SLOW_MAX = 4'd15;

    localparam int DUTY_LUT_DEPTH = 64;

    typedef logic [DUTY_LUT_DEPTH-1:0][DUTY_W-1:0] t_duty_lut;

    typedef struct packed {
        logic [TRIG_W-1:0]  trig_low;
        logic [TRIG_W-1:0]  trig_high;
        logic [LIMIT_W-1:0] echo_wait;
        logic [LIMIT_W-1:0] echo_max;
        logic [BLINK_W-1:0] blink;
    } t_cfg;

    function automatic t_duty_lut duty_lut_build();
        t_duty_lut lut;
        for (int d = 0; d < DUTY_LUT_DEPTH; d++) begin
            if (d >= int'(FAR_CM)) begin
                lut[d] = DUTY_FAR;
            end else if (d <= int'(NEAR_CM)) begin
                lut[d] = DUTY_NEAR;
            end else begin
                lut[d] = DUTY_W'(255 - ((d - 12) * 229 + 33) / 34);
            end
        end
        return lut;
    endfunction

    localparam t_duty_lut DUTY_LUT = duty_lut_build();

endpackage

// ===== sv/ultrasonic_ranger_brightness.sv =====
// Top level of the ultrasonic ranger with distance-driven LED brightness.
//
// One beat in, one beat out: every accepted action (timer tick, start, slow
// overflow tick) yields exactly one result beat with the trigger level, busy
// and done flags, the last distance, the LED duty and the blink LED level.
// The block accepts one beat per clock while the result beat is not stalled; a
// beat passes an input register and is then resolved against the measurement
// state into the registered result beat. A stalled result beat holds the
// measurement state; the input register then takes one more beat before the
// input stalls. The path that sets the clock is the tick increment, the echo
// width to distance multiply (16 x 26 bits) and the duty lookup. COUNT_WIDTH
// sets the width of the phase tick counter.
module ultrasonic_ranger_brightness
    import urb_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [1:0]             i_action,
    input  logic                   i_echo_level,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_trigger_level,
    output logic                   o_busy_res,
    output logic                   o_done_res,
    output logic                   o_timed_out,
    output logic [DIST_W-1:0]      o_distance_cm,
    output logic [DUTY_W-1:0]      o_brightness,
    output logic                   o_blink_led
);

    localparam int CMPW = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TRIG_LOW,
        PH_TRIG_HIGH,
        PH_WAIT_ECHO,
        PH_MEASURE
    } t_phase;

    t_cfg cfg;

    logic                   r_in_valid;
    logic [1:0]             r_in_action;
    logic                   r_in_echo;
    logic                   r_out_valid;
    logic                   r_done;
    t_phase                 r_phase,  n_phase;
    logic [COUNT_WIDTH-1:0] r_tick,   n_tick;
    logic [DIST_W-1:0]      r_dist,   n_dist;
    logic                   r_to,     n_to;
    logic [DUTY_W-1:0]      r_duty,   n_duty;
    logic [BLINK_W-1:0]     r_slow,   n_slow;
    logic                   r_blink,  n_blink;
    logic                   n_done;

    logic                   out_free;
    logic                   advance;
    logic [COUNT_WIDTH-1:0] bumped;
    logic                   fin;
    logic                   fin_timeout;
    logic [COUNT_WIDTH-1:0] fin_ticks;
    logic [DIST_W-1:0]      calc_dist;
    logic [DUTY_W-1:0]      calc_duty;

    urb_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    urb_dist #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dist (
        .i_ticks    (fin_ticks),
        .i_timeout  (fin_timeout),
        .o_distance (calc_dist),
        .o_duty     (calc_duty)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    always_comb begin
        bumped      = (r_tick == CNT_MAX) ? r_tick : r_tick + COUNT_WIDTH'(1);
        n_phase     = r_phase;
        n_tick      = r_tick;
        n_slow      = r_slow;
        fin         = 1'b0;
        fin_timeout = 1'b0;
        fin_ticks   = r_tick;

        case (r_in_action)
            ACT_START: begin
                if (r_phase == PH_IDLE) begin
                    n_phase = PH_TRIG_LOW;
                    n_tick  = '0;
                end
            end
            ACT_SLOW: begin
                if (r_slow < SLOW_MAX) begin
                    n_slow = r_slow + BLINK_W'(1);
                end
            end
            ACT_TICK: begin
                case (r_phase)
                    PH_IDLE: ;
                    PH_TRIG_LOW: begin
                        n_tick = bumped;
                        if (CMPW'(bumped) >= CMPW'(cfg.trig_low)) begin
                            n_phase = PH_TRIG_HIGH;
                            n_tick  = '0;
                        end
                    end
                    PH_TRIG_HIGH: begin
                        n_tick = bumped;
                        if (CMPW'(bumped) >= CMPW'(cfg.trig_high)) begin
                            n_phase = PH_WAIT_ECHO;
                            n_tick  = '0;
                        end
                    end
                    PH_WAIT_ECHO: begin
                        if (r_in_echo) begin
                            n_phase = PH_MEASURE;
                            n_tick  = '0;
                        end else begin
                            n_tick = bumped;
                            if (CMPW'(bumped) >= CMPW'(cfg.echo_wait)) begin
                                fin         = 1'b1;
                                fin_timeout = 1'b1;
                            end
                        end
                    end
                    PH_MEASURE: begin
                        if (r_in_echo) begin
                            n_tick    = bumped;
                            fin_ticks = bumped;
                            if (CMPW'(bumped) > CMPW'(cfg.echo_max) || bumped == CNT_MAX) begin
                                fin = 1'b1;
                            end
                        end else begin
                            fin = 1'b1;
                        end
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
            default: ;
        endcase

        n_dist  = r_dist;
        n_to    = r_to;
        n_duty  = r_duty;
        n_blink = r_blink;
        n_done  = fin;
        if (fin) begin
            n_dist  = calc_dist;
            n_to    = fin_timeout;
            n_duty  = calc_duty;
            n_phase = PH_IDLE;
            n_tick  = '0;
            if (calc_dist < NEAR_CM || calc_dist > FAR_CM) begin
                // out of range: toggle once enough slow ticks have gathered
                if (r_slow >= cfg.blink) begin
                    n_blink = !r_blink;
                    n_slow  = '0;
                end
            end else begin
                n_blink = 1'b1;
                n_slow  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_done      <= 1'b0;
            r_phase     <= PH_IDLE;
            r_tick      <= '0;
            r_dist      <= '0;
            r_to        <= 1'b0;
            r_duty      <= '0;
            r_slow      <= '0;
            r_blink     <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid  <= i_in_valid;
                r_in_action <= i_action;
                r_in_echo   <= i_echo_level;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            // hold all measurement state while the result beat is stalled
            if (advance) begin
                r_done  <= n_done;
                r_phase <= n_phase;
                r_tick  <= n_tick;
                r_dist  <= n_dist;
                r_to    <= n_to;
                r_duty  <= n_duty;
                r_slow  <= n_slow;
                r_blink <= n_blink;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_trigger_level = (r_phase == PH_TRIG_HIGH);
    assign o_busy_res      = (r_phase != PH_IDLE);
    assign o_done_res      = r_done;
    assign o_timed_out     = r_to;
    assign o_distance_cm   = r_dist;
    assign o_brightness    = r_duty;
    assign o_blink_led     = r_blink;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> !o_busy_res && r_tick == '0)
        else $error("completed measurement left the ranger busy");

    a_trig_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_trigger_level |-> o_busy_res)
        else $error("trigger driven high outside a measurement");

    a_timeout_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_timed_out |-> o_distance_cm == '0 && o_brightness == DUTY_NEAR)
        else $error("timeout reported with a nonzero distance");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> $stable(r_phase) && $stable(r_slow))
        else $error("measurement state moved while result beat stalled");

endmodule

// ===== sv/urb_cfg.sv =====
// Configuration register file of the ultrasonic ranger.
module urb_cfg
    import urb_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trig_low  <= RST_TRIG_LOW;
            r_cfg.trig_high <= RST_TRIG_HIGH;
            r_cfg.echo_wait <= RST_ECHO_WAIT;
            r_cfg.echo_max  <= RST_ECHO_MAX;
            r_cfg.blink     <= RST_BLINK;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TRIG_LOW:  r_cfg.trig_low  <= i_cfg_data[TRIG_W-1:0];
                CFG_TRIG_HIGH: r_cfg.trig_high <= i_cfg_data[TRIG_W-1:0];
                CFG_ECHO_WAIT: r_cfg.echo_wait <= i_cfg_data[LIMIT_W-1:0];
                CFG_ECHO_MAX:  r_cfg.echo_max  <= i_cfg_data[LIMIT_W-1:0];
                CFG_BLINK:     r_cfg.blink     <= i_cfg_data[BLINK_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/urb_dist.sv =====
// Echo width to distance and LED duty conversion.
module urb_dist
    import urb_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic [COUNT_WIDTH-1:0] i_ticks,
    input  logic                   i_timeout,
    output logic [DIST_W-1:0]      o_distance,
    output logic [DUTY_W-1:0]      o_duty
);

    localparam int CMPW   = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;
    localparam int PROD_W = LIMIT_W + DIST_RECIP_W;

    logic               sat;
    logic [LIMIT_W-1:0] ticks_clamped;
    logic [PROD_W-1:0]  prod;
    logic [DIST_W-1:0]  dist_cm;

    always_comb begin
        sat           = CMPW'(i_ticks) >= CMPW'(DIST_SAT_TICKS);
        ticks_clamped = sat ? '0 : LIMIT_W'(i_ticks);
        prod          = PROD_W'(ticks_clamped) * PROD_W'(DIST_RECIP);
        if (i_timeout) begin
            dist_cm = '0;
        end else if (sat) begin
            dist_cm = DIST_MAX;
        end else begin
            dist_cm = prod[DIST_SHIFT +: DIST_W];
        end
        // table covers the near and ramp zones; everything beyond it is far
        if (dist_cm < DIST_W'(DUTY_LUT_DEPTH)) begin
            o_duty = DUTY_LUT[dist_cm[$clog2(DUTY_LUT_DEPTH)-1:0]];
        end else begin
            o_duty = DUTY_FAR;
        end
        o_distance = dist_cm;
    end

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the ultrasonic ranger: predicts every result beat and compares.
module testbench
    import urb_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ACT_NOP = 2'd3;
    localparam int RESET_CYCLES = 6;
    localparam int DRAIN_CYCLES = 6;
    localparam int IDLE_PCT     = 19;
    localparam int QUIET_FROM   = 900;
    localparam int QUIET_TO     = 1250;
    localparam int HOLD_AT      = 450;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_REPORTS  = 10;
    localparam int PHASE_BEATS  = 60;
    localparam int RANDOM_PHASES = 6;
    localparam int SWEEP_RUNS   = 2;
    localparam logic [LIMIT_W-1:0] TICK_MAX = '1;

    typedef enum logic [2:0] {
        PH_IDLE, PH_TRIG_LOW, PH_TRIG_HIGH, PH_WAIT_ECHO, PH_MEASURE
    } t_ranger_phase;

    typedef struct packed {
        logic [1:0] action;
        logic       echo;
    } t_ranger_beat;

    typedef struct packed {
        logic              trigger;
        logic              busy;
        logic              done;
        logic              timed_out;
        logic [DIST_W-1:0] distance;
        logic [DUTY_W-1:0] duty;
        logic              blink;
    } t_reading;

    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   i_cfg_we     = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data   = '0;
    logic                   i_in_valid   = 1'b0;
    logic [1:0]             i_action     = ACT_TICK;
    logic                   i_echo_level = 1'b0;
    logic                   i_out_ready  = 1'b0;
    logic                   o_in_ready;
    logic                   o_out_valid;
    logic                   o_trigger_level;
    logic                   o_busy_res;
    logic                   o_done_res;
    logic                   o_timed_out;
    logic [DIST_W-1:0]      o_distance_cm;
    logic [DUTY_W-1:0]      o_brightness;
    logic                   o_blink_led;

    ultrasonic_ranger_brightness uut (.*);

    // ranger model state, at its reset values
    t_cfg ranger_cfg = '{RST_TRIG_LOW, RST_TRIG_HIGH, RST_ECHO_WAIT, RST_ECHO_MAX, RST_BLINK};
    t_ranger_phase      ph           = PH_IDLE;
    logic [LIMIT_W-1:0] ticks        = '0;
    logic [DIST_W-1:0]  dist_cm      = '0;
    logic               timeout_flag = 1'b0;
    logic [DUTY_W-1:0]  duty         = '0;
    logic [BLINK_W-1:0] slow_ticks   = '0;
    logic               blink        = 1'b0;

    t_ranger_beat pending_beats[$];
    t_reading     expected_readings[$];
    t_ranger_beat next_beat;
    t_reading     got;
    t_reading     want;
    bit           in_taken     = 1'b0;
    bit           hold_off     = 1'b0;
    int           beats_loaded = 0;
    int           beats_in     = 0;
    int           beats_out    = 0;
    int           mismatches   = 0;
    int           phase_beats  = 0;
    int           noise_pct    = 0;

    always #5ns i_clk = ~i_clk;

    function automatic logic [LIMIT_W-1:0] count_up(logic [LIMIT_W-1:0] c);
        return (c == TICK_MAX) ? c : c + 1'b1;
    endfunction

    function automatic logic [DUTY_W-1:0] duty_for_cm(logic [DIST_W-1:0] cm);
        if (cm >= FAR_CM) return DUTY_FAR;
        if (cm <= NEAR_CM) return DUTY_NEAR;
        return DUTY_W'(255 - ((int'(cm) - int'(NEAR_CM)) * 229 + 33) / 34);
    endfunction

    function automatic void close_measurement(bit no_echo);
        int unsigned cm;
        cm = no_echo ? 0 : (int'(ticks) * 343) / 40000;
        dist_cm = (cm > DIST_MAX) ? DIST_MAX : DIST_W'(cm);
        timeout_flag = no_echo;
        duty = duty_for_cm(dist_cm);
        if (dist_cm < NEAR_CM || dist_cm > FAR_CM) begin
            if (slow_ticks >= ranger_cfg.blink) begin
                blink = ~blink;
                slow_ticks = '0;
            end
        end else begin
            blink = 1'b1;
            slow_ticks = '0;
        end
        ph = PH_IDLE;
        ticks = '0;
    endfunction

    function automatic t_reading ranger_predict(t_ranger_beat b);
        t_reading r;
        logic ended;
        ended = 1'b0;
        case (b.action)
            ACT_START: begin
                if (ph == PH_IDLE) begin
                    ph = PH_TRIG_LOW;
                    ticks = '0;
                end
            end
            ACT_SLOW: begin
                if (slow_ticks != SLOW_MAX) slow_ticks = slow_ticks + 1'b1;
            end
            ACT_TICK: begin
                case (ph)
                    PH_TRIG_LOW: begin
                        ticks = count_up(ticks);
                        if (ticks >= ranger_cfg.trig_low) begin
                            ph = PH_TRIG_HIGH;
                            ticks = '0;
                        end
                    end
                    PH_TRIG_HIGH: begin
                        ticks = count_up(ticks);
                        if (ticks >= ranger_cfg.trig_high) begin
                            ph = PH_WAIT_ECHO;
                            ticks = '0;
                        end
                    end
                    PH_WAIT_ECHO: begin
                        if (b.echo) begin
                            ph = PH_MEASURE;
                            ticks = '0;
                        end else begin
                            ticks = count_up(ticks);
                            if (ticks >= ranger_cfg.echo_wait) begin
                                close_measurement(1'b1);
                                ended = 1'b1;
                            end
                        end
                    end
                    PH_MEASURE: begin
                        if (b.echo) begin
                            ticks = count_up(ticks);
                            if (ticks > ranger_cfg.echo_max || ticks == TICK_MAX) begin
                                close_measurement(1'b0);
                                ended = 1'b1;
                            end
                        end else begin
                            close_measurement(1'b0);
                            ended = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        r.trigger   = (ph == PH_TRIG_HIGH);
        r.busy      = (ph != PH_IDLE);
        r.done      = ended;
        r.timed_out = timeout_flag;
        r.distance  = dist_cm;
        r.duty      = duty;
        r.blink     = blink;
        return r;
    endfunction

    function automatic string show_reading(t_reading r);
        return $sformatf("trig=%0b busy=%0b done=%0b tmo=%0b dist=%0d duty=%0d blink=%0b",
                         r.trigger, r.busy, r.done, r.timed_out, r.distance, r.duty, r.blink);
    endfunction

    // no idling at all while the quiet window of beats passes
    function automatic bit take_break();
        if (beats_in >= QUIET_FROM && beats_in < QUIET_TO) return 1'b0;
        return $urandom_range(99) < IDLE_PCT;
    endfunction

    // check result beats, then predict the beat accepted at this edge
    always @(posedge i_clk) begin
        in_taken = i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_trigger_level, o_busy_res, o_done_res, o_timed_out,
                    o_distance_cm, o_brightness, o_blink_led};
            beats_out++;
            if (expected_readings.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result %0d with nothing expected: %s", beats_out, show_reading(got));
            end else begin
                want = expected_readings.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("result %0d mismatch", beats_out);
                        $display("  expected %s", show_reading(want));
                        $display("  actual   %s", show_reading(got));
                    end
                end
            end
        end
        if (in_taken) begin
            expected_readings.push_back(ranger_predict(t_ranger_beat'{i_action, i_echo_level}));
            beats_in++;
        end
    end

    // hold the payload until taken, then advance or idle
    always @(negedge i_clk) begin
        if (!i_in_valid || in_taken) begin
            if (i_rst_n && pending_beats.size() != 0 && !take_break()) begin
                next_beat = pending_beats.pop_front();
                i_action     <= next_beat.action;
                i_echo_level <= next_beat.echo;
                i_in_valid   <= 1'b1;
                beats_loaded++;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= !hold_off && !take_break();
    end

    // stall the receiver long enough for the block to back up its input
    initial begin
        wait (beats_in >= HOLD_AT);
        @(posedge i_clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off = 1'b0;
    end

    initial begin
        #30ms;
        $display("testbench: FAIL");
        $finish;
    end

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_TRIG_LOW:  ranger_cfg.trig_low  = data[TRIG_W-1:0];
            CFG_TRIG_HIGH: ranger_cfg.trig_high = data[TRIG_W-1:0];
            CFG_ECHO_WAIT: ranger_cfg.echo_wait = data[LIMIT_W-1:0];
            CFG_ECHO_MAX:  ranger_cfg.echo_max  = data[LIMIT_W-1:0];
            CFG_BLINK:     ranger_cfg.blink     = data[BLINK_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // upper data bits carry junk; only the register's own width counts
    task automatic program_ranger(logic [TRIG_W-1:0] lo, logic [TRIG_W-1:0] hi,
                                  logic [LIMIT_W-1:0] wait_lim, logic [LIMIT_W-1:0] cap,
                                  logic [BLINK_W-1:0] blinks);
        write_reg(CFG_TRIG_LOW, {8'($urandom), lo});
        write_reg(CFG_TRIG_HIGH, {8'($urandom), hi});
        write_reg(CFG_ECHO_WAIT, wait_lim);
        write_reg(CFG_ECHO_MAX, cap);
        write_reg(CFG_BLINK, {12'($urandom), blinks});
    endtask

    // wait until every beat is through and the block has drained
    task automatic settle();
        @(negedge i_clk);
        while (pending_beats.size() != 0 || beats_loaded != beats_in ||
               expected_readings.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic queue_beat(logic [1:0] act, logic echo);
        pending_beats.push_back(t_ranger_beat'{act, echo});
        phase_beats++;
    endtask

    task automatic queue_tick(logic echo);
        if (noise_pct != 0 && $urandom_range(99) < noise_pct) begin
            case ($urandom_range(3))
                0, 1:    queue_beat(ACT_SLOW, 1'($urandom));
                2:       queue_beat(ACT_START, 1'($urandom));
                default: queue_beat(ACT_NOP, 1'($urandom));
            endcase
        end
        queue_beat(ACT_TICK, echo);
    endtask

    // start, trigger ticks, echo-low gap, echo-high width, echo fall
    task automatic queue_measurement(int unsigned gap, int unsigned width);
        int unsigned trig;
        trig = (ranger_cfg.trig_low == 0 ? 1 : int'(ranger_cfg.trig_low))
             + (ranger_cfg.trig_high == 0 ? 1 : int'(ranger_cfg.trig_high));
        queue_beat(ACT_START, 1'($urandom));
        repeat (trig) queue_tick(1'($urandom));
        repeat (gap) queue_tick(1'b0);
        repeat (width + 1) queue_tick(1'b1);
        queue_tick(1'b0);
    endtask

    initial begin
        int unsigned gap;
        int unsigned width;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // idle block: a tick, unused action and a slow tick change nothing visible
        queue_beat(ACT_TICK, 1'b1);
        queue_beat(ACT_NOP, 1'b0);
        queue_beat(ACT_NOP, 1'b1);
        queue_beat(ACT_SLOW, 1'b0);
        settle();

        // short pulses: start while busy, plain echo, timeout, width cap
        program_ranger(8'd1, 8'd1, 16'd3, 16'd5, 4'd0);
        queue_beat(ACT_START, 1'b1);
        queue_measurement(1, 3);
        queue_measurement(3, 0);
        queue_measurement(0, 6);
        settle();

        // all registers zero, then stray writes to unused indexes
        program_ranger('0, '0, '0, '0, '0);
        for (int r = int'(CFG_BLINK) + 1; r < (1 << CFG_INDEX_W); r++)
            write_reg(CFG_INDEX_W'(r), 16'($urandom));
        queue_measurement(0, 0);
        queue_measurement(1, 0);
        settle();

        noise_pct = 8;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            program_ranger(p == 2 ? '1 : TRIG_W'($urandom_range(0, 5)),
                           p == 2 ? '1 : TRIG_W'($urandom_range(0, 5)),
                           LIMIT_W'($urandom_range(0, 30)),
                           p == 4 ? '1 : LIMIT_W'($urandom_range(0, 60)),
                           p == 3 ? SLOW_MAX : BLINK_W'($urandom_range(0, 15)));
            phase_beats = 0;
            while (phase_beats < PHASE_BEATS) begin
                case ($urandom_range(9))
                    0: begin
                        // broken sequence: start, then arbitrary beats
                        queue_beat(ACT_START, 1'($urandom));
                        repeat ($urandom_range(1, 8)) queue_beat(2'($urandom), 1'($urandom));
                    end
                    1: repeat ($urandom_range(1, 16)) queue_beat(ACT_SLOW, 1'($urandom));
                    default: begin
                        gap = ($urandom_range(5) == 0) ? int'(ranger_cfg.echo_wait) + 1
                                                       : $urandom_range(0, 4);
                        width = ($urandom_range(5) == 0 && ranger_cfg.echo_max < 100)
                              ? int'(ranger_cfg.echo_max) + $urandom_range(0, 2)
                              : $urandom_range(0, 40);
                        queue_measurement(gap, width);
                    end
                endcase
            end
            settle();
        end

        // echo widths of a few hundred ticks give distances of zero to two centimetres
        program_ranger(RST_TRIG_LOW, RST_TRIG_HIGH, RST_ECHO_WAIT, RST_ECHO_MAX,
                       BLINK_W'($urandom_range(0, 4)));
        noise_pct = 3;
        repeat (SWEEP_RUNS) queue_measurement($urandom_range(0, 50), $urandom_range(100, 300));
        settle();

        if (mismatches == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

// ===== ultrasonic_ranger_brightness.f =====
sv/urb_pkg.sv
sv/urb_cfg.sv
sv/urb_dist.sv
sv/ultrasonic_ranger_brightness.sv
verif/testbench.sv
